### rtl/qis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qis_pkg: shared constants and types of the quadratic index stretch
// Index and ratio widths, register codes, reset values and the word that
// moves through the divider pipeline.
// ----------------------------------------------------------------------------
package qis_pkg;

	// index width and derived widths
	localparam int INDEX_BITS = 12;
	localparam int MP_BITS    = INDEX_BITS + 1;
	localparam int FRAC_BITS  = 16;
	localparam int RATIO_BITS = 18;
	localparam int SQ_BITS    = 2 * INDEX_BITS;
	localparam int DEN_BITS   = SQ_BITS + 1;
	// ratio numerator: d^2 * 2^17 + span^2
	localparam int RN_BITS    = SQ_BITS + FRAC_BITS + 2;
	// shift numerator: 2 * d^2 * distance + span^2
	localparam int SN_BITS    = 3 * INDEX_BITS + 2;
	localparam int DIV_STAGES = (RATIO_BITS > INDEX_BITS) ? RATIO_BITS : INDEX_BITS;

	localparam logic [RATIO_BITS-1:0] RATIO_ONE = RATIO_BITS'(1 << FRAC_BITS);
	localparam logic [RATIO_BITS-1:0] RATIO_MAX = '1;

	// configuration port
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = MP_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MOVE_POINT    = 2'd0,
		REG_MOVE_DISTANCE = 2'd1,
		REG_ANCHOR_POINT  = 2'd2,
		REG_AXIS_SIZE     = 2'd3
	} cfg_reg_t;

	localparam logic [MP_BITS-1:0]    MOVE_POINT_RST    = '1;
	localparam logic [INDEX_BITS-1:0] MOVE_DISTANCE_RST = '0;
	localparam logic [INDEX_BITS-1:0] ANCHOR_POINT_RST  = '0;
	localparam logic [INDEX_BITS-1:0] AXIS_SIZE_RST     = INDEX_BITS'(4095);

	// word carried through the divider stages
	typedef struct packed {
		logic [INDEX_BITS-1:0] idx;
		logic                  left;
		logic                  in_range;
		logic                  active;
		logic                  sat;
		logic [DEN_BITS-1:0]   den;
		logic [RN_BITS-1:0]    rem_r;
		logic [RATIO_BITS-1:0] q_r;
		logic [SN_BITS-1:0]    rem_s;
		logic [INDEX_BITS-1:0] q_s;
	} qis_div_t;

endpackage
`default_nettype wire

### rtl/qis_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qis_if: channel interfaces of the quadratic index stretch
// Input word, result word and configuration write channel, each with
// valid/ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface qis_item_if;
	import qis_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] target_index;

	modport source (output valid, target_index, input ready);
	modport sink   (input valid, target_index, output ready);
endinterface

interface qis_result_if;
	import qis_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [INDEX_BITS-1:0] source_index;
	logic [RATIO_BITS-1:0] sq_ratio;
	logic                  in_range;
	logic                  stretch_active;

	modport source (output valid, source_index, sq_ratio, in_range, stretch_active,
		input ready);
	modport sink   (input valid, source_index, sq_ratio, in_range, stretch_active,
		output ready);
endinterface

interface qis_cfg_if;
	import qis_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/qis_divpipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qis_divpipe: pipelined restoring divider, two lanes
// Ratio lane: one quotient bit per stage; shift lane: one in each of the last
// INDEX_BITS, over the same divisor. Each stage holds its word until the next frees.
// ----------------------------------------------------------------------------
module qis_divpipe (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire qis_pkg::qis_div_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output qis_pkg::qis_div_t     out_data
);
	import qis_pkg::*;

	qis_div_t              data_s  [DIV_STAGES];
	qis_div_t              nxt     [DIV_STAGES];
	logic [DIV_STAGES-1:0] valid_s;
	logic [DIV_STAGES:0]   rdy;

	// ready chain: a stage loads when empty or when its successor moves
	always_comb begin
		rdy[DIV_STAGES] = out_ready;
		for (int j = DIV_STAGES - 1; j >= 0; j--) begin
			rdy[j] = !valid_s[j] || rdy[j+1];
		end
	end

	// one quotient bit per stage for each lane that has bit K, most significant first
	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		localparam int K = DIV_STAGES - 1 - j;
		qis_div_t              src;
		logic [RN_BITS-1:0]    rr;
		logic [RATIO_BITS-1:0] qr;
		logic [SN_BITS-1:0]    rs;
		logic [INDEX_BITS-1:0] qs;

		if (j == 0) begin : g_first
			assign src = in_data;
		end else begin : g_next
			assign src = data_s[j-1];
		end

		if (K < RATIO_BITS) begin : g_ratio
			logic [RN_BITS-1:0] dr;
			logic               ge;
			assign dr = RN_BITS'(src.den) << K;
			assign ge = src.rem_r >= dr;
			assign rr = ge ? src.rem_r - dr : src.rem_r;
			assign qr = ge ? (src.q_r | (RATIO_BITS'(1) << K)) : src.q_r;
		end else begin : g_ratio_hold
			assign rr = src.rem_r;
			assign qr = src.q_r;
		end

		if (K < INDEX_BITS) begin : g_shift
			logic [SN_BITS-1:0] ds;
			logic               ge;
			assign ds = SN_BITS'(src.den) << K;
			assign ge = src.rem_s >= ds;
			assign rs = ge ? src.rem_s - ds : src.rem_s;
			assign qs = ge ? (src.q_s | (INDEX_BITS'(1) << K)) : src.q_s;
		end else begin : g_shift_hold
			assign rs = src.rem_s;
			assign qs = src.q_s;
		end

		assign nxt[j] = '{idx: src.idx, left: src.left, in_range: src.in_range,
			active: src.active, sat: src.sat, den: src.den,
			rem_r: rr, q_r: qr, rem_s: rs, q_s: qs};
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			if (rdy[0]) begin
				valid_s[0] <= in_valid;
			end
			for (int j = 1; j < DIV_STAGES; j++) begin
				if (rdy[j]) begin
					valid_s[j] <= valid_s[j-1];
				end
			end
		end
	end

	// advance stage words
	always_ff @(posedge clk) begin
		for (int j = 0; j < DIV_STAGES; j++) begin
			if (rdy[j]) begin
				data_s[j] <= nxt[j];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_data  = data_s[DIV_STAGES-1];

endmodule
`default_nettype wire

### rtl/quadratic_index_stretch.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_index_stretch: quadratic axis stretch index remapper
// Gives, for each target index, the index to copy from, the squared
// distance ratio in UQ2.16 and the range and active flags.
// ----------------------------------------------------------------------------
// Channels: item (target_index in), result (source_index, sq_ratio,
// in_range, stretch_active out), cfg (register index and data, always ready).
// Write cfg only while no word is in flight; registers feed the pipeline
// directly.
// Throughput: one word per cycle, sustained while result is taken.
// Pipeline: 22 register stages, three front stages (range check, squares,
// numerators), 18 divider stages (one ratio quotient bit per stage, set by
// the 18-bit ratio), one output register.
// Reset: registers take their reset values (stretch disabled), the
// pipeline empties.
// Stall: when result is not taken, each stage holds its word; empty stages
// behind keep filling, so item.ready drops only once every stage is full.
// ----------------------------------------------------------------------------
module quadratic_index_stretch (
	input  wire logic  clk,
	input  wire logic  arst_n,
	qis_item_if.sink   item,
	qis_result_if.source result,
	qis_cfg_if.sink    cfg
);
	import qis_pkg::*;

	localparam int SAT_BITS = DEN_BITS + RATIO_BITS;

	// configuration registers
	logic [MP_BITS-1:0]    mp_q;
	logic [INDEX_BITS-1:0] dist_q;
	logic [INDEX_BITS-1:0] anc_q;
	logic [INDEX_BITS-1:0] size_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mp_q   <= MOVE_POINT_RST;
			dist_q <= MOVE_DISTANCE_RST;
			anc_q  <= ANCHOR_POINT_RST;
			size_q <= AXIS_SIZE_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_MOVE_POINT:    mp_q   <= cfg.data;
				REG_MOVE_DISTANCE: dist_q <= cfg.data[INDEX_BITS-1:0];
				REG_ANCHOR_POINT:  anc_q  <= cfg.data[INDEX_BITS-1:0];
				REG_AXIS_SIZE:     size_q <= cfg.data[INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	// stretch geometry from the registers
	logic [INDEX_BITS-1:0] p_u;
	logic                  p_left, p_right, left_ok, right_ok, active;
	logic [INDEX_BITS-1:0] lo_left;
	logic [INDEX_BITS:0]   hi_right;
	logic [INDEX_BITS-1:0] span_abs;

	always_comb begin
		p_u      = mp_q[INDEX_BITS-1:0];
		p_left   = !mp_q[INDEX_BITS] && (p_u < anc_q);
		p_right  = !mp_q[INDEX_BITS] && (p_u > anc_q);
		left_ok  = p_u >= dist_q;
		lo_left  = p_u - dist_q;
		hi_right = {1'b0, p_u} + {1'b0, dist_q};
		right_ok = hi_right <= {1'b0, size_q};
		active   = (p_left && left_ok) || (p_right && right_ok);
		span_abs = p_left ? (anc_q - lo_left) : (hi_right[INDEX_BITS-1:0] - anc_q);
	end

	// pipeline handshake
	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;
	logic div_in_ready, div_out_valid, out_rdy;
	qis_div_t div_out;

	assign rdy_s3     = !v_s3 || div_in_ready;
	assign rdy_s2     = !v_s2 || rdy_s3;
	assign rdy_s1     = !v_s1 || rdy_s2;
	assign item.ready = rdy_s1;

	// stage 1: distance to anchor and range check
	logic [INDEX_BITS-1:0] idx_s1, ad_s1, as_s1;
	logic                  left_s1, inr_s1, act_s1;
	logic                  in_left, in_right;
	logic [INDEX_BITS-1:0] ti;

	always_comb begin
		ti       = item.target_index;
		in_left  = (ti >= lo_left) && (ti < anc_q);
		in_right = (ti > anc_q) && ({1'b0, ti} <= hi_right);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			idx_s1  <= ti;
			ad_s1   <= (ti >= anc_q) ? ti - anc_q : anc_q - ti;
			as_s1   <= span_abs;
			left_s1 <= p_left;
			act_s1  <= active;
			inr_s1  <= active && (p_left ? in_left : in_right);
		end
	end

	// stage 2: squares
	logic [INDEX_BITS-1:0] idx_s2;
	logic [SQ_BITS-1:0]    d2_s2, sq_s2;
	logic                  left_s2, inr_s2, act_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			idx_s2  <= idx_s1;
			d2_s2   <= ad_s1 * ad_s1;
			sq_s2   <= as_s1 * as_s1;
			left_s2 <= left_s1;
			inr_s2  <= inr_s1;
			act_s2  <= act_s1;
		end
	end

	// stage 3: rounded numerators, divisor and saturation check
	logic [SQ_BITS+INDEX_BITS-1:0] prod;
	logic [RN_BITS-1:0]            num_r;
	logic [SN_BITS-1:0]            num_s;
	logic [DEN_BITS-1:0]           den;
	qis_div_t                      div_in_s3;

	always_comb begin
		prod  = d2_s2 * dist_q;
		num_r = RN_BITS'({d2_s2, {(FRAC_BITS + 1){1'b0}}}) + RN_BITS'(sq_s2);
		num_s = SN_BITS'({prod, 1'b0}) + SN_BITS'(sq_s2);
		den   = {sq_s2, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			div_in_s3.idx      <= idx_s2;
			div_in_s3.left     <= left_s2;
			div_in_s3.in_range <= inr_s2;
			div_in_s3.active   <= act_s2;
			div_in_s3.sat      <= SAT_BITS'(num_r) >= {den, {RATIO_BITS{1'b0}}};
			div_in_s3.den      <= den;
			div_in_s3.rem_r    <= num_r;
			div_in_s3.q_r      <= '0;
			div_in_s3.rem_s    <= num_s;
			div_in_s3.q_s      <= '0;
		end
	end

	// divider stages
	qis_divpipe u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (div_in_ready),
		.in_data   (div_in_s3),
		.out_valid (div_out_valid),
		.out_ready (out_rdy),
		.out_data  (div_out)
	);

	// output register: select ratio and apply the shift
	logic                  res_valid_q;
	logic [INDEX_BITS-1:0] source_index_q;
	logic [RATIO_BITS-1:0] sq_ratio_q;
	logic                  in_range_q, stretch_active_q;
	logic [INDEX_BITS-1:0] src_idx;
	logic [RATIO_BITS-1:0] ratio;

	assign out_rdy = !res_valid_q || result.ready;

	always_comb begin
		if (!div_out.active) begin
			ratio = RATIO_ONE;
		end else if (div_out.sat) begin
			ratio = RATIO_MAX;
		end else begin
			ratio = div_out.q_r;
		end
		if (!div_out.in_range) begin
			src_idx = div_out.idx;
		end else if (div_out.left) begin
			src_idx = div_out.idx + div_out.q_s;
		end else begin
			src_idx = div_out.idx - div_out.q_s;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_rdy) begin
			res_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy) begin
			source_index_q   <= src_idx;
			sq_ratio_q       <= ratio;
			in_range_q       <= div_out.in_range;
			stretch_active_q <= div_out.active;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.source_index   = source_index_q;
	assign result.sq_ratio       = sq_ratio_q;
	assign result.in_range       = in_range_q;
	assign result.stretch_active = stretch_active_q;

endmodule
`default_nettype wire
